### src/ptc_pkg.sv
// Shared types, widths and constants of the pressure and temperature compensation block.
`default_nettype none

package ptc_pkg;

  localparam int RAW_W   = 24;
  localparam int VALUE_W = 32;
  localparam int COEF_W  = 16;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int IDX_W   = 3;

  localparam int DT_W    = 26;
  localparam int MUL_W   = 26;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int TEMP_W  = 20;
  localparam int CORR_W  = 44;
  localparam int ACC_W   = 64;
  localparam int SPLIT_W = 22;

  localparam int REF_SH     = 8;
  localparam int TEMP_SH    = 23;
  localparam int TI_LOW_SH  = 33;
  localparam int TI_HIGH_SH = 37;
  localparam int OFF_REF_SH = 16;
  localparam int SNS_REF_SH = 15;
  localparam int OFF_SH     = 7;
  localparam int SNS_SH     = 8;
  localparam int SENS_SH    = 21;
  localparam int P_SH       = 13;
  localparam int OFFI_SH    = 1;
  localparam int SENSI_SH   = 3;
  localparam int OFFH_SH    = 4;

  localparam int TEMP_REF  = 2000;
  localparam int TEMP_VLOW = -1500;

  localparam logic CMD_TEMP  = 1'b0;
  localparam logic CMD_PRESS = 1'b1;

  localparam logic [IDX_W-1:0] REG_SENS_AT_REF       = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFFSET_AT_REF     = 3'd1;
  localparam logic [IDX_W-1:0] REG_SENS_TEMP_COEFF   = 3'd2;
  localparam logic [IDX_W-1:0] REG_OFFSET_TEMP_COEFF = 3'd3;
  localparam logic [IDX_W-1:0] REG_REF_TEMPERATURE   = 3'd4;
  localparam logic [IDX_W-1:0] REG_TEMP_SENSITIVITY  = 3'd5;

  typedef struct packed {
    logic [COEF_W-1:0] sens_at_ref;
    logic [COEF_W-1:0] offset_at_ref;
    logic [COEF_W-1:0] sens_temp_coeff;
    logic [COEF_W-1:0] offset_temp_coeff;
    logic [COEF_W-1:0] ref_temperature;
    logic [COEF_W-1:0] temp_sensitivity;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_M_TEMP,
    OP_M_SQ,
    OP_TEMP_OUT,
    OP_M_OFF,
    OP_M_SENS,
    OP_M_D,
    OP_M_E,
    OP_CORR1,
    OP_CORR2,
    OP_M_LO,
    OP_M_HI,
    OP_ACC,
    OP_PRESS_OUT
  } op_e;

  typedef struct packed {
    logic load;
    op_e  op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_press;
  } dp_status_t;

endpackage

`default_nettype wire

### src/ptc_stream_if.sv
// Request channel interfaces for raw readings in and compensated values out.
`default_nettype none

interface ptc_in_if import ptc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             command;
  logic [RAW_W-1:0] adc_value;

  modport source (output valid, output command, output adc_value, input ready);
  modport sink (input valid, input command, input adc_value, output ready);
endinterface

interface ptc_out_if import ptc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      is_pressure;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output is_pressure, output value, input ready);
  modport sink (input valid, input is_pressure, input value, output ready);
endinterface

`default_nettype wire

### src/ptc_regs.sv
// APB-style register file holding the six calibration coefficients.
`default_nettype none

module ptc_regs import ptc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t             cfg_q;
  logic [IDX_W-1:0] idx;
  logic             wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SENS_AT_REF:       cfg_q.sens_at_ref       <= pwdata[COEF_W-1:0];
        REG_OFFSET_AT_REF:     cfg_q.offset_at_ref     <= pwdata[COEF_W-1:0];
        REG_SENS_TEMP_COEFF:   cfg_q.sens_temp_coeff   <= pwdata[COEF_W-1:0];
        REG_OFFSET_TEMP_COEFF: cfg_q.offset_temp_coeff <= pwdata[COEF_W-1:0];
        REG_REF_TEMPERATURE:   cfg_q.ref_temperature   <= pwdata[COEF_W-1:0];
        REG_TEMP_SENSITIVITY:  cfg_q.temp_sensitivity  <= pwdata[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SENS_AT_REF:       prdata = DATA_W'(cfg_q.sens_at_ref);
      REG_OFFSET_AT_REF:     prdata = DATA_W'(cfg_q.offset_at_ref);
      REG_SENS_TEMP_COEFF:   prdata = DATA_W'(cfg_q.sens_temp_coeff);
      REG_OFFSET_TEMP_COEFF: prdata = DATA_W'(cfg_q.offset_temp_coeff);
      REG_REF_TEMPERATURE:   prdata = DATA_W'(cfg_q.ref_temperature);
      REG_TEMP_SENSITIVITY:  prdata = DATA_W'(cfg_q.temp_sensitivity);
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### src/ptc_ctrl.sv
// Sequencer that steps the datapath through the temperature or pressure computation.
`default_nettype none

module ptc_ctrl import ptc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_M_TEMP,
    S_M_SQ,
    S_TEMP_OUT,
    S_M_OFF,
    S_M_SENS,
    S_M_D,
    S_M_E,
    S_CORR1,
    S_CORR2,
    S_M_LO,
    S_M_HI,
    S_ACC,
    S_PRESS_OUT
  } state_e;

  state_e state_q;
  state_e state_d;
  op_e    op;
  logic   out_valid_q;
  logic   out_free;
  logic   out_load;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = '{load: in_valid_i && (state_q == S_IDLE), op: op};
  assign out_load    = (op == OP_TEMP_OUT) || (op == OP_PRESS_OUT);

  always_comb begin
    state_d = state_q;
    op      = OP_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_M_TEMP;
      end
      S_M_TEMP: begin
        op      = OP_M_TEMP;
        state_d = status_i.is_press ? S_M_OFF : S_M_SQ;
      end
      S_M_SQ: begin
        op      = OP_M_SQ;
        state_d = S_TEMP_OUT;
      end
      S_TEMP_OUT: begin
        if (out_free) begin
          op      = OP_TEMP_OUT;
          state_d = S_IDLE;
        end
      end
      S_M_OFF: begin
        op      = OP_M_OFF;
        state_d = S_M_SENS;
      end
      S_M_SENS: begin
        op      = OP_M_SENS;
        state_d = S_M_D;
      end
      S_M_D: begin
        op      = OP_M_D;
        state_d = S_M_E;
      end
      S_M_E: begin
        op      = OP_M_E;
        state_d = S_CORR1;
      end
      S_CORR1: begin
        op      = OP_CORR1;
        state_d = S_CORR2;
      end
      S_CORR2: begin
        op      = OP_CORR2;
        state_d = S_M_LO;
      end
      S_M_LO: begin
        op      = OP_M_LO;
        state_d = S_M_HI;
      end
      S_M_HI: begin
        op      = OP_M_HI;
        state_d = S_ACC;
      end
      S_ACC: begin
        op      = OP_ACC;
        state_d = S_PRESS_OUT;
      end
      S_PRESS_OUT: begin
        if (out_free) begin
          op      = OP_PRESS_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### src/ptc_dpath.sv
// Datapath with the shared multiplier, working registers and stored raw readings.
`default_nettype none

module ptc_dpath import ptc_pkg::*; #(
  parameter int ADC_BITS = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  ctrl_cmd_t                 cmd_i,
  input  logic                      command_i,
  input  logic [RAW_W-1:0]          adc_value_i,
  output dp_status_t                status_o,
  output logic                      is_pressure_o,
  output logic signed [VALUE_W-1:0] value_o
);

  logic [ADC_BITS-1:0]       raw;
  logic [ADC_BITS-1:0]       last_temp_q;
  logic [ADC_BITS-1:0]       last_press_q;
  logic                      is_press_q;
  logic                      out_press_q;
  logic signed [VALUE_W-1:0] value_q;

  logic signed [DT_W-1:0]    ref_term;
  logic signed [DT_W-1:0]    dt_d;
  logic signed [DT_W-1:0]    dt_q;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [TEMP_W-1:0]  d_new;
  logic signed [TEMP_W-1:0]  d_q;
  logic signed [TEMP_W-1:0]  e_q;

  logic signed [CORR_W-1:0]  off_new;
  logic signed [CORR_W-1:0]  sens_new;
  logic signed [CORR_W-1:0]  off_q;
  logic signed [CORR_W-1:0]  sens_q;
  logic signed [CORR_W-1:0]  dd_q;
  logic signed [CORR_W-1:0]  ee;
  logic signed [CORR_W-1:0]  dd3;
  logic signed [CORR_W-1:0]  dd5;
  logic signed [CORR_W-1:0]  ee7;
  logic signed [CORR_W-1:0]  ee4;
  logic signed [CORR_W-1:0]  offi_d;
  logic signed [CORR_W-1:0]  sensi_d;
  logic signed [CORR_W-1:0]  offi_q;
  logic signed [CORR_W-1:0]  sensi_q;

  logic [PROD_W-1:0]         sq_u;
  logic [PROD_W-1:0]         ti;
  logic signed [VALUE_W-1:0] temp_full;
  logic signed [VALUE_W-1:0] temp_value;

  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [ACC_W-1:0]   p_full;

  assign raw      = adc_value_i[ADC_BITS-1:0];
  assign ref_term = $signed(DT_W'({cfg_i.ref_temperature, {REF_SH{1'b0}}}));

  always_comb begin
    if (command_i == CMD_PRESS) begin
      dt_d = $signed(DT_W'(last_temp_q)) - ref_term;
    end else begin
      dt_d = $signed(DT_W'(raw)) - ref_term;
    end
  end

  always_comb begin
    unique case (cmd_i.op)
      OP_M_TEMP: begin
        mul_a = dt_q;
        mul_b = $signed(MUL_W'(cfg_i.temp_sensitivity));
      end
      OP_M_SQ: begin
        mul_a = dt_q;
        mul_b = dt_q;
      end
      OP_M_OFF: begin
        mul_a = dt_q;
        mul_b = $signed(MUL_W'(cfg_i.offset_temp_coeff));
      end
      OP_M_SENS: begin
        mul_a = dt_q;
        mul_b = $signed(MUL_W'(cfg_i.sens_temp_coeff));
      end
      OP_M_D: begin
        mul_a = MUL_W'(d_q);
        mul_b = MUL_W'(d_q);
      end
      OP_M_E: begin
        mul_a = MUL_W'(e_q);
        mul_b = MUL_W'(e_q);
      end
      OP_M_LO: begin
        mul_a = $signed(MUL_W'(last_press_q));
        mul_b = $signed(MUL_W'(sens_q[SPLIT_W-1:0]));
      end
      OP_M_HI: begin
        mul_a = $signed(MUL_W'(last_press_q));
        mul_b = MUL_W'($signed(sens_q[CORR_W-1:SPLIT_W]));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  assign d_new    = prod_q[TEMP_SH+TEMP_W-1:TEMP_SH];
  assign off_new  = $signed(CORR_W'({cfg_i.offset_at_ref, {OFF_REF_SH{1'b0}}}))
                  + CORR_W'(prod_q >>> OFF_SH);
  assign sens_new = $signed(CORR_W'({cfg_i.sens_at_ref, {SNS_REF_SH{1'b0}}}))
                  + CORR_W'(prod_q >>> SNS_SH);

  assign ee  = prod_q[CORR_W-1:0];
  assign dd3 = dd_q + (dd_q <<< 1);
  assign dd5 = dd_q + (dd_q <<< 2);
  assign ee7 = (ee <<< 3) - ee;
  assign ee4 = ee <<< 2;

  always_comb begin
    if (d_q[TEMP_W-1]) begin
      offi_d  = dd3 >>> OFFI_SH;
      sensi_d = dd5 >>> SENSI_SH;
      if (e_q[TEMP_W-1]) begin
        offi_d  = offi_d + ee7;
        sensi_d = sensi_d + ee4;
      end
    end else begin
      offi_d  = dd_q >>> OFFH_SH;
      sensi_d = '0;
    end
  end

  assign sq_u = prod_q;

  always_comb begin
    if (d_q[TEMP_W-1]) begin
      ti = (sq_u + (sq_u << 1)) >> TI_LOW_SH;
    end else begin
      ti = (sq_u << 1) >> TI_HIGH_SH;
    end
  end

  assign temp_full  = VALUE_W'(d_q) + VALUE_W'(TEMP_REF);
  assign temp_value = temp_full - $signed(ti[VALUE_W-1:0]);

  assign prod_ext = ACC_W'(prod_q);
  assign p_full   = (acc_q >>> SENS_SH) - ACC_W'(off_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_temp_q  <= '0;
      last_press_q <= '0;
    end else if (cmd_i.load) begin
      if (command_i == CMD_PRESS) begin
        last_press_q <= raw;
      end else begin
        last_temp_q <= raw;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      is_press_q <= command_i;
      dt_q       <= dt_d;
    end
    if (cmd_i.op != OP_NOP) begin
      prod_q <= prod_d;
    end
    case (cmd_i.op)
      OP_M_SQ: begin
        d_q <= d_new;
      end
      OP_TEMP_OUT: begin
        value_q     <= temp_value;
        out_press_q <= is_press_q;
      end
      OP_M_OFF: begin
        d_q <= d_new;
        e_q <= d_new + TEMP_W'(TEMP_REF - TEMP_VLOW);
      end
      OP_M_SENS: begin
        off_q <= off_new;
      end
      OP_M_D: begin
        sens_q <= sens_new;
      end
      OP_M_E: begin
        dd_q <= prod_q[CORR_W-1:0];
      end
      OP_CORR1: begin
        offi_q  <= offi_d;
        sensi_q <= sensi_d;
      end
      OP_CORR2: begin
        off_q  <= off_q - offi_q;
        sens_q <= sens_q - sensi_q;
      end
      OP_M_HI: begin
        acc_q <= prod_ext;
      end
      OP_ACC: begin
        acc_q <= acc_q + (prod_ext <<< SPLIT_W);
      end
      OP_PRESS_OUT: begin
        value_q     <= p_full[P_SH+VALUE_W-1:P_SH];
        out_press_q <= is_press_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o.is_press = is_press_q;
  assign is_pressure_o     = out_press_q;
  assign value_o           = value_q;

endmodule

`default_nettype wire

### src/pressure_temperature_compensation.sv
// Top level of the pressure and temperature compensation block.
// Each accepted reading yields one result. The sequencer steps each reading one item at a time
// through the single shared 26 by 26 bit multiplier and takes no new reading until it has
// returned to idle. A finished result waits in the output register while the next reading is
// accepted; the sequencer holds at its last step only if the previous result has not been
// taken yet.
// The coefficients are written through the APB port at byte address 4*i, register i; the user
// must write them only while the block is idle, which the block itself does not enforce.
// Pressure uses the latest temperature reading, zero after reset.
`default_nettype none

module pressure_temperature_compensation import ptc_pkg::*; #(
  parameter int ADC_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ptc_in_if.sink            in_ch,
  ptc_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  ptc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ptc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ptc_dpath #(
    .ADC_BITS (ADC_BITS)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .command_i     (in_ch.command),
    .adc_value_i   (in_ch.adc_value),
    .status_o      (status),
    .is_pressure_o (out_ch.is_pressure),
    .value_o       (out_ch.value)
  );

endmodule

`default_nettype wire
